/* design/msp_rfp_pkg.sv */
package msp_rfp_pkg;

  // Largest accepted payload, default for the top-level parameter
  localparam int unsigned MSP_MAX_PAYLOAD = 64;

  // Frame header characters
  localparam logic [7:0] START_CH  = 8'h24;  // '$'
  localparam logic [7:0] HDR_M_CH  = 8'h4D;  // 'M'
  localparam logic [7:0] HDR_LT_CH = 8'h3C;  // '<'

  localparam int unsigned TIMEOUT_W     = 24;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd200000;

  // Input item kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [7:0] {
    ST_START  = 8'b0000_0001,
    ST_HDR_M  = 8'b0000_0010,
    ST_HDR_LT = 8'b0000_0100,
    ST_LEN    = 8'b0000_1000,
    ST_CMD    = 8'b0001_0000,
    ST_DATA   = 8'b0010_0000,
    ST_CSUM   = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_e;

endpackage

/* design/msp_request_frame_parser.sv */
// Channel | Dir    | Handshake                 | Beat fields
// --------+--------+---------------------------+-----------------------------------------
// in      | input  | in_valid_i / in_ready_o   | op_i, rx_byte_i
// out     | output | out_valid_o / out_ready_i | command_o .. last_o (six fields)
// cfg     | input  | cfg_valid_i / cfg_ready_o | idle_timeout_ticks_i
//
// Readout: a good checksum with N payload bytes walks the RAM one entry per cycle
// while the output is not stalled, with input held off for the whole walk; each result
// passes the state change into ST_EMIT, then the registered RAM read, then the output
// register. An empty frame's beat is in the output the next cycle.
// Reset: asynchronous, active low; hunt for '$', timeout 200000, RAM not cleared.
// Stalls: output stalls back up the readout; a checksum beat waits for a free output.
module msp_request_frame_parser
  import msp_rfp_pkg::*;
#(
  parameter int unsigned MaxPayload = MSP_MAX_PAYLOAD
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // received byte / tick beats
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 op_i,
  input  logic [7:0]           rx_byte_i,
  // result beats
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           command_o,
  output logic [6:0]           payload_length_o,
  output logic [7:0]           data_byte_o,
  output logic [5:0]           byte_index_o,
  output logic                 has_data_o,
  output logic                 last_o,
  // idle timeout register write
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [TIMEOUT_W-1:0] idle_timeout_ticks_i
);

  localparam int unsigned AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam logic [8:0]  MaxP9 = 9'(MaxPayload);

  // parser state
  state_e               state_q, state_d;
  logic [7:0]           cmd_q, cmd_d;
  logic [7:0]           len_q, len_d;
  logic [7:0]           xor_q, xor_d;
  logic [7:0]           wp_q, wp_d;
  logic [7:0]           rd_cnt_q, rd_cnt_d;
  logic [TIMEOUT_W-1:0] idle_q, idle_d;
  logic [TIMEOUT_W-1:0] timeout_q;

  // payload RAM
  logic [7:0]           mem [MaxPayload];
  logic                 mem_we;
  logic [AddrW-1:0]     mem_waddr;
  logic                 rd_en;
  logic [7:0]           mem_rd_q;

  // RAM read stage: sideband travelling with the read data
  logic                 p1_valid_q, p1_valid_d;
  logic [7:0]           p1_cmd_q;
  logic [7:0]           p1_len_q;
  logic [7:0]           p1_idx_q;
  logic                 p1_last_q;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_cmd_q;
  logic [6:0]           out_len_q;
  logic [7:0]           out_data_q;
  logic [5:0]           out_idx_q;
  logic                 out_has_q;
  logic                 out_last_q;

  logic                 out_free;
  logic                 p1_adv;
  logic                 empty_load;
  logic                 in_acc;
  logic                 timed_out;
  state_e               eff_state;
  logic [8:0]           wp_inc;
  logic [8:0]           rd_inc;

  assign out_free = !out_valid_q || out_ready_i;
  assign p1_adv   = p1_valid_q && out_free;

  // No input during readout; the checksum beat may need the output slot.
  assign in_ready_o  = (state_q != ST_EMIT) &&
                       ((state_q != ST_CSUM) || (!p1_valid_q && out_free));
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign timed_out = idle_q > timeout_q;
  assign eff_state = timed_out ? ST_START : state_q;
  assign wp_inc    = {1'b0, wp_q} + 9'd1;
  assign rd_inc    = {1'b0, rd_cnt_q} + 9'd1;

  // Reads happen only in ST_EMIT and writes only in ST_DATA, so the RAM
  // never sees a read and a write to the same entry in one cycle.
  assign rd_en = (state_q == ST_EMIT) && (!p1_valid_q || out_free);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    len_d      = len_q;
    xor_d      = xor_q;
    wp_d       = wp_q;
    rd_cnt_d   = rd_cnt_q;
    idle_d     = idle_q;
    mem_we     = 1'b0;
    mem_waddr  = wp_q[AddrW-1:0];
    empty_load = 1'b0;

    if (in_acc && (op_i == OP_TICK)) begin
      if (idle_q != {TIMEOUT_W{1'b1}}) begin
        idle_d = idle_q + 1'b1;
      end
    end else if (in_acc) begin
      idle_d = '0;
      case (eff_state)
        ST_HDR_M: begin
          state_d = (rx_byte_i == HDR_M_CH) ? ST_HDR_LT : ST_START;
        end
        ST_HDR_LT: begin
          if (rx_byte_i == HDR_LT_CH) begin
            xor_d   = '0;
            len_d   = '0;
            state_d = ST_LEN;
          end else begin
            state_d = ST_START;
          end
        end
        ST_LEN: begin
          if ({1'b0, rx_byte_i} <= MaxP9) begin
            len_d   = rx_byte_i;
            wp_d    = '0;
            xor_d   = xor_q ^ rx_byte_i;
            state_d = ST_CMD;
          end else begin
            state_d = ST_START;
          end
        end
        ST_CMD: begin
          cmd_d   = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          state_d = (len_q == 8'd0) ? ST_CSUM : ST_DATA;
        end
        ST_DATA: begin
          xor_d  = xor_q ^ rx_byte_i;
          mem_we = {1'b0, wp_q} < MaxP9;
          wp_d   = wp_inc[7:0];
          if (wp_inc >= {1'b0, len_q}) begin
            state_d = ST_CSUM;
          end
        end
        ST_CSUM: begin
          state_d = ST_START;
          if (xor_q == rx_byte_i) begin
            if (len_q == 8'd0) begin
              empty_load = 1'b1;
            end else begin
              rd_cnt_d = '0;
              state_d  = ST_EMIT;
            end
          end
        end
        default: begin
          state_d = (rx_byte_i == START_CH) ? ST_HDR_M : ST_START;
        end
      endcase
    end

    // readout walk, input is held off here
    if (rd_en) begin
      rd_cnt_d = rd_inc[7:0];
      if (rd_inc >= {1'b0, len_q}) begin
        state_d = ST_START;
      end
    end
  end

  always_comb begin
    p1_valid_d = p1_valid_q;
    if (p1_adv) begin
      p1_valid_d = 1'b0;
    end
    if (rd_en) begin
      p1_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (p1_adv || empty_load) begin
      out_valid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_START;
      cmd_q       <= '0;
      len_q       <= '0;
      xor_q       <= '0;
      wp_q        <= '0;
      rd_cnt_q    <= '0;
      idle_q      <= '0;
      timeout_q   <= TIMEOUT_RESET;
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      len_q       <= len_d;
      xor_q       <= xor_d;
      wp_q        <= wp_d;
      rd_cnt_q    <= rd_cnt_d;
      idle_q      <= idle_d;
      p1_valid_q  <= p1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= idle_timeout_ticks_i;
      end
    end
  end

  // payload RAM, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      mem_rd_q <= mem[rd_cnt_q[AddrW-1:0]];
    end
  end

  // sideband of the read in flight; frame fields are stable during readout
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      p1_cmd_q  <= cmd_q;
      p1_len_q  <= len_q;
      p1_idx_q  <= rd_cnt_q;
      p1_last_q <= rd_inc == {1'b0, len_q};
    end
  end

  // output register: either a RAM result or the single empty-frame beat
  always_ff @(posedge clk_i) begin
    if (p1_adv) begin
      out_cmd_q  <= p1_cmd_q;
      out_len_q  <= p1_len_q[6:0];
      out_data_q <= mem_rd_q;
      out_idx_q  <= p1_idx_q[5:0];
      out_has_q  <= 1'b1;
      out_last_q <= p1_last_q;
    end else if (empty_load) begin
      out_cmd_q  <= cmd_q;
      out_len_q  <= len_q[6:0];
      out_data_q <= '0;
      out_idx_q  <= '0;
      out_has_q  <= 1'b0;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign command_o        = out_cmd_q;
  assign payload_length_o = out_len_q;
  assign data_byte_o      = out_data_q;
  assign byte_index_o     = out_idx_q;
  assign has_data_o       = out_has_q;
  assign last_o           = out_last_q;

endmodule

/* design/msp_rfp_checker.sv */
module msp_rfp_checker
  import msp_rfp_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [7:0]           command_o,
  input logic [6:0]           payload_length_o,
  input logic [7:0]           data_byte_o,
  input logic [5:0]           byte_index_o,
  input logic                 has_data_o,
  input logic                 last_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable({command_o,
      payload_length_o, data_byte_o, byte_index_o, has_data_o, last_o}))
    else $error("result beat changed while stalled");

  // empty frame beat is a lone, zeroed, last beat
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_data_o |-> last_o && byte_index_o == 6'd0 &&
      data_byte_o == 8'd0 && payload_length_o == 7'd0)
    else $error("malformed empty-frame beat");

  // data beats stay within the frame
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_data_o |-> {1'b0, byte_index_o} < payload_length_o)
    else $error("byte index beyond payload length");

  // last data beat carries the final index
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_data_o && last_o |->
      7'({1'b0, byte_index_o} + 7'd1) == payload_length_o)
    else $error("last beat not at final index");

endmodule

bind msp_request_frame_parser msp_rfp_checker u_msp_rfp_checker (.*);

/* tb/sv/tb_msp_request_frame_parser.sv */
module tb_msp_request_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import msp_rfp_pkg::*;

  // Idle cycles with no beat on any channel before the run is abandoned.
  // Worst legal stretch: the longest sender gap or receiver stall, or the
  // settle at the end; this leaves a wide margin.
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned ITEMS_PER_PHASE = 4;
  localparam int unsigned NUM_PHASES = 6;

  // One result beat, in port order
  typedef struct packed {
    logic [7:0] command;
    logic [6:0] payload_length;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       has_data;
    logic       last;
  } frame_beat_t;

  // How a directed row is checked: by the parser model, or by a typed-in
  // answer (nothing, or exactly one beat)
  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_NONE,
    CHK_ONE
  } row_check_e;

  typedef struct packed {
    logic        op;
    logic [7:0]  rx;
    row_check_e  check;
    frame_beat_t want;
  } stim_row_t;

  localparam frame_beat_t NO_BEAT = '0;

  localparam stim_row_t DIRECTED_ROWS [28] = '{
    // empty frame: checksum equals the command, single beat without data
    '{OP_BYTE, START_CH,  CHK_PRED, NO_BEAT},
    '{OP_BYTE, HDR_M_CH,  CHK_PRED, NO_BEAT},
    '{OP_BYTE, HDR_LT_CH, CHK_PRED, NO_BEAT},
    '{OP_BYTE, 8'h00,     CHK_PRED, NO_BEAT},
    '{OP_BYTE, 8'hA5,     CHK_PRED, NO_BEAT},
    '{OP_BYTE, 8'hA5,     CHK_ONE,  '{8'hA5, 7'd0, 8'h00, 6'd0, 1'b0, 1'b1}},
    // one-byte frame, command 0x00, data 0xFF, checksum 01^00^FF
    '{OP_BYTE, START_CH,  CHK_PRED, NO_BEAT},
    '{OP_BYTE, HDR_M_CH,  CHK_PRED, NO_BEAT},
    '{OP_BYTE, HDR_LT_CH, CHK_PRED, NO_BEAT},
    '{OP_BYTE, 8'h01,     CHK_PRED, NO_BEAT},
    '{OP_BYTE, 8'h00,     CHK_PRED, NO_BEAT},
    '{OP_BYTE, 8'hFF,     CHK_PRED, NO_BEAT},
    '{OP_BYTE, 8'hFE,     CHK_ONE,  '{8'h00, 7'd1, 8'hFF, 6'd0, 1'b1, 1'b1}},
    // checksum mismatch: nothing comes out
    '{OP_BYTE, START_CH,  CHK_PRED, NO_BEAT},
    '{OP_BYTE, HDR_M_CH,  CHK_PRED, NO_BEAT},
    '{OP_BYTE, HDR_LT_CH, CHK_PRED, NO_BEAT},
    '{OP_BYTE, 8'h00,     CHK_PRED, NO_BEAT},
    '{OP_BYTE, 8'h5A,     CHK_PRED, NO_BEAT},
    '{OP_BYTE, 8'h5B,     CHK_NONE, NO_BEAT},
    // second '$' is a wrong header byte and does not start a new frame
    '{OP_BYTE, START_CH,  CHK_PRED, NO_BEAT},
    '{OP_BYTE, START_CH,  CHK_PRED, NO_BEAT},
    '{OP_BYTE, HDR_M_CH,  CHK_PRED, NO_BEAT},
    '{OP_BYTE, HDR_LT_CH, CHK_PRED, NO_BEAT},
    // length byte above the maximum payload
    '{OP_BYTE, START_CH,  CHK_PRED, NO_BEAT},
    '{OP_BYTE, HDR_M_CH,  CHK_PRED, NO_BEAT},
    '{OP_BYTE, HDR_LT_CH, CHK_PRED, NO_BEAT},
    '{OP_BYTE, 8'hFF,     CHK_NONE, NO_BEAT},
    // tick beat, byte lane ignored
    '{OP_TICK, 8'hFF,     CHK_NONE, NO_BEAT}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 op_i = OP_BYTE;
  logic [7:0]           rx_byte_i = 8'h00;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [7:0]           command_o;
  logic [6:0]           payload_length_o;
  logic [7:0]           data_byte_o;
  logic [5:0]           byte_index_o;
  logic                 has_data_o;
  logic                 last_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [TIMEOUT_W-1:0] idle_timeout_ticks_i = '0;

  always #5 clk_i = ~clk_i;

  msp_request_frame_parser dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .op_i                (op_i),
    .rx_byte_i           (rx_byte_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .command_o           (command_o),
    .payload_length_o    (payload_length_o),
    .data_byte_o         (data_byte_o),
    .byte_index_o        (byte_index_o),
    .has_data_o          (has_data_o),
    .last_o              (last_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .idle_timeout_ticks_i(idle_timeout_ticks_i)
  );

  // ---------------------------------------------------------------------
  // Parser model: own copy of the register and the parse state
  // ---------------------------------------------------------------------
  logic [TIMEOUT_W-1:0] idle_limit = TIMEOUT_RESET;
  state_e               hunt_state = ST_START;
  logic [7:0]           cur_command = '0;
  logic [6:0]           cur_length = '0;
  logic [7:0]           running_xor = '0;
  logic [6:0]           fill_pos = '0;
  logic [7:0]           payload_copy [MSP_MAX_PAYLOAD];
  logic [TIMEOUT_W-1:0] silent_ticks = '0;

  frame_beat_t frame_beats_new [$];   // beats caused by the latest input beat
  frame_beat_t expected_beats  [$];   // beats still owed by the DUT

  int unsigned errors = 0;
  int unsigned sent_items = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  bit          quiet_stretch = 1'b0;  // no gaps, no new stalls while set
  frame_beat_t seen_beat;
  frame_beat_t owed_beat;

  function void parse_rx(input logic op, input logic [7:0] b);
    int i;
    frame_beat_t fb;
    frame_beats_new.delete();
    if (op == OP_TICK) begin
      // saturating silence counter
      if (silent_ticks != '1) silent_ticks = silent_ticks + 1'b1;
      return;
    end
    // gap strictly above the limit drops any half-parsed frame
    if (silent_ticks > idle_limit) hunt_state = ST_START;
    silent_ticks = '0;
    case (hunt_state)
      ST_HDR_M: begin
        hunt_state = (b == HDR_M_CH) ? ST_HDR_LT : ST_START;
      end
      ST_HDR_LT: begin
        if (b == HDR_LT_CH) begin
          running_xor = '0;
          cur_length  = '0;
          hunt_state  = ST_LEN;
        end else begin
          hunt_state = ST_START;
        end
      end
      ST_LEN: begin
        if (b <= MSP_MAX_PAYLOAD) begin
          cur_length  = b[6:0];
          fill_pos    = '0;
          running_xor = running_xor ^ b;
          hunt_state  = ST_CMD;
        end else begin
          hunt_state = ST_START;
        end
      end
      ST_CMD: begin
        cur_command = b;
        running_xor = running_xor ^ b;
        hunt_state  = (cur_length == 0) ? ST_CSUM : ST_DATA;
      end
      ST_DATA: begin
        running_xor = running_xor ^ b;
        payload_copy[fill_pos[5:0]] = b;
        fill_pos = fill_pos + 1'b1;
        if (fill_pos >= cur_length) hunt_state = ST_CSUM;
      end
      ST_CSUM: begin
        if (running_xor == b) begin
          if (cur_length == 0) begin
            fb = '{cur_command, 7'd0, 8'h00, 6'd0, 1'b0, 1'b1};
            frame_beats_new.push_back(fb);
          end else begin
            for (i = 0; i < int'(cur_length); i++) begin
              fb = '{cur_command, cur_length, payload_copy[i], 6'(i), 1'b1,
                     i == int'(cur_length) - 1};
              frame_beats_new.push_back(fb);
            end
          end
        end
        hunt_state = ST_START;
      end
      default: begin
        hunt_state = (b == START_CH) ? ST_HDR_M : ST_START;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Input side: one beat per call, random gap in front of it. Valid stays
  // high across back-to-back beats; it only drops when a gap is taken.
  // ---------------------------------------------------------------------
  task automatic send_item(input logic op, input logic [7:0] b,
                           input row_check_e chk, input frame_beat_t typed);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (quiet_stretch || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sent_items++;
    // model always advances; typed rows override what it owes
    parse_rx(op, b);
    case (chk)
      CHK_ONE:  expected_beats.push_back(typed);
      CHK_NONE: ;
      default:  foreach (frame_beats_new[k]) expected_beats.push_back(frame_beats_new[k]);
    endcase
  endtask

  // Byte beat, sometimes preceded by a run of ticks. With a small limit the
  // run mostly sits at the limit or one above it, so both sides of the timeout hit.
  task automatic send_rx(input logic [7:0] b);
    int ticks;
    int r;
    if ($urandom_range(0, 9) == 0) begin
      r = $urandom_range(0, 2);
      if (idle_limit > 6) ticks = $urandom_range(1, 6);
      else if (r == 0) ticks = int'(idle_limit) + 1;
      else if (r == 1) ticks = (idle_limit == 0) ? 1 : int'(idle_limit);
      else ticks = $urandom_range(1, int'(idle_limit) + 1);
      repeat (ticks) send_item(OP_TICK, 8'($urandom), CHK_PRED, NO_BEAT);
    end
    send_item(OP_BYTE, b, CHK_PRED, NO_BEAT);
  endtask

  // One random sequence: mostly a well-formed frame (full size if asked), else a
  // broken header, an oversized length or line noise.
  task automatic run_random_sequence(input bit full_frame);
    int kind;
    int n;
    logic [7:0] len;
    logic [7:0] cmd;
    logic [7:0] sum;
    logic [7:0] d;
    quiet_stretch = ($urandom_range(0, 4) == 0);
    kind = full_frame ? 0 : $urandom_range(0, 99);
    if (kind < 70) begin
      if (full_frame) len = 8'(MSP_MAX_PAYLOAD);
      else if ($urandom_range(0, 7) == 0) len = 8'($urandom_range(9, MSP_MAX_PAYLOAD));
      else len = 8'($urandom_range(0, 8));
      cmd = 8'($urandom);
      sum = len ^ cmd;
      send_rx(START_CH);
      send_rx(HDR_M_CH);
      send_rx(HDR_LT_CH);
      send_rx(len);
      send_rx(cmd);
      for (n = 0; n < int'(len); n++) begin
        d = 8'($urandom);
        sum = sum ^ d;
        send_rx(d);
      end
      // corrupt one checksum bit now and then
      if ($urandom_range(0, 6) == 0) sum = sum ^ (8'h01 << $urandom_range(0, 7));
      send_rx(sum);
    end else if (kind < 80) begin
      send_rx(START_CH);
      if ($urandom_range(0, 1) == 0) begin
        do d = 8'($urandom); while (d == HDR_M_CH);
        send_rx(d);
      end else begin
        send_rx(HDR_M_CH);
        do d = 8'($urandom); while (d == HDR_LT_CH);
        send_rx(d);
      end
    end else if (kind < 88) begin
      send_rx(START_CH);
      send_rx(HDR_M_CH);
      send_rx(HDR_LT_CH);
      d = ($urandom_range(0, 2) == 0) ? 8'(MSP_MAX_PAYLOAD + 1)
                                      : 8'($urandom_range(MSP_MAX_PAYLOAD + 1, 255));
      send_rx(d);
    end else begin
      repeat ($urandom_range(1, 4)) send_rx(8'($urandom));
    end
  endtask

  // Register write only once the parser is idle: all owed beats are out,
  // then a wait so that a readout or a checksum with no result can settle.
  task automatic write_idle_limit(input logic [TIMEOUT_W-1:0] v);
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_valid_i          <= 1'b1;
    idle_timeout_ticks_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    idle_limit = v;
  endtask

  // ---------------------------------------------------------------------
  // Output side: random back-pressure, short stalls mostly, a few long
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet_stretch && $urandom_range(0, 99) < 25) begin
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                 : $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Result check: every accepted beat against the oldest owed beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_beat = '{command_o, payload_length_o, data_byte_o, byte_index_o,
                    has_data_o, last_o};
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat cmd=%h len=%0d data=%h idx=%0d has=%b last=%b",
                 $time, seen_beat.command, seen_beat.payload_length,
                 seen_beat.data_byte, seen_beat.byte_index, seen_beat.has_data,
                 seen_beat.last);
        errors++;
      end else begin
        owed_beat = expected_beats.pop_front();
        if (seen_beat !== owed_beat) begin
          $display("%0t: mismatch exp cmd=%h len=%0d data=%h idx=%0d has=%b last=%b",
                   $time, owed_beat.command, owed_beat.payload_length,
                   owed_beat.data_byte, owed_beat.byte_index, owed_beat.has_data,
                   owed_beat.last);
          $display("%0t:          got cmd=%h len=%0d data=%h idx=%0d has=%b last=%b",
                   $time, seen_beat.command, seen_beat.payload_length,
                   seen_beat.data_byte, seen_beat.byte_index, seen_beat.has_data,
                   seen_beat.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles in a row with no beat on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress, %0d beats still owed", $time, expected_beats.size());
      $display("[msp_request_frame_parser] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  logic [TIMEOUT_W-1:0] phase_limits [NUM_PHASES];

  initial begin
    // limits: extremes, zero, small values for the timeout edge, reset value
    phase_limits[0] = 24'd1;
    phase_limits[1] = '1;
    phase_limits[2] = '0;
    phase_limits[3] = 24'd3;
    phase_limits[4] = TIMEOUT_W'($urandom_range(2, 12));
    phase_limits[5] = TIMEOUT_RESET;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows at the reset timeout
    foreach (DIRECTED_ROWS[r]) begin
      send_item(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].rx, DIRECTED_ROWS[r].check,
                DIRECTED_ROWS[r].want);
    end

    // random phases, one limit each; a full-size payload forced in one of them
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_idle_limit(phase_limits[p]);
      sent_items = 0;
      if (p == 1) run_random_sequence(1'b1);
      while (sent_items < ITEMS_PER_PHASE) run_random_sequence(1'b0);
    end

    // drain, then let the block settle
    in_valid_i <= 1'b0;
    quiet_stretch = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("[msp_request_frame_parser] OK");
    end else begin
      $display("[msp_request_frame_parser] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/msp_rfp_pkg.sv
design/msp_request_frame_parser.sv
design/msp_rfp_checker.sv
tb/sv/tb_msp_request_frame_parser.sv
